/* sv/tsrq_pkg.sv */
package tsrq_pkg;

  // Queue depth and stored payload width.
  localparam int unsigned CAPACITY     = 128;
  localparam int unsigned PAYLOAD_BITS = 32;

  // Fixed field widths of the item and result ports.
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned PORT_PL_W = 32;
  localparam int unsigned ECNT_W   = 8;

  // Width of the fill counter, wide enough to hold CAPACITY itself.
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic {
    KIND_PUT = 1'b0,
    KIND_GET = 1'b1
  } kind_e;

  typedef enum logic {
    ERR_NONE = 1'b0,
    ERR_FULL = 1'b1
  } err_e;

  typedef logic [TIME_W-1:0]       time_t;
  typedef logic [ID_W-1:0]         id_t;
  typedef logic [PAYLOAD_BITS-1:0] pl_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  // One stored request.
  typedef struct packed {
    time_t req_time;
    id_t   request_id;
    pl_t   payload;
  } entry_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic  ins;   // insert the new entry at its sorted place
    logic  rem;   // drop the head, everything moves one cell forward
    time_t key;   // start time of the entry to insert
  } cmd_t;

endpackage

/* sv/tsrq_cell.sv */
module tsrq_cell (
  input  logic            clk_i,
  input  tsrq_pkg::cmd_t   cmd_i,
  input  tsrq_pkg::entry_t new_i,
  input  tsrq_pkg::entry_t left_i,
  input  logic            left_later_i,
  input  tsrq_pkg::entry_t right_i,
  input  logic            occ_i,
  output tsrq_pkg::entry_t entry_o,
  output logic            later_o
);
  import tsrq_pkg::*;

  entry_t entry_q;
  entry_t entry_d;

  // An empty cell counts as later than any key, so the new entry lands in the
  // first free cell when no stored time is strictly later.
  assign later_o = !occ_i || (entry_q.req_time > cmd_i.key);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins && later_o) begin
      entry_d = left_later_i ? left_i : new_i;
    end else if (cmd_i.rem) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

/* sv/time_sorted_request_queue.sv */
// Latency: the result of an item appears on the result ports, with done_o high,
// in the cycle right after the clock edge that accepted the item.
// Throughput: one item per cycle; busy_o is never raised, because the chain of
// cells compares all stored start times against the key and shifts in one step.
// Reset: rst_ni clears the fill count and the result strobe; stored entries are
// not cleared and are only read below the fill count.
module time_sorted_request_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     kind_i,
  input  logic [tsrq_pkg::TIME_W-1:0]    start_time_i,
  input  logic [tsrq_pkg::ID_W-1:0]      request_id_i,
  input  logic [tsrq_pkg::PORT_PL_W-1:0] payload_i,
  output logic                     done_o,
  output logic                     out_valid_o,
  output logic [tsrq_pkg::TIME_W-1:0]    out_start_time_o,
  output logic [tsrq_pkg::ID_W-1:0]      out_request_id_o,
  output logic [tsrq_pkg::PORT_PL_W-1:0] out_payload_o,
  output logic                     error_code_o,
  output logic [tsrq_pkg::ECNT_W-1:0]    entry_count_o
);
  import tsrq_pkg::*;

  // The queue is a row of CAPACITY cells, cell 0 holding the earliest entry.
  // A put broadcasts its key; every cell compares, and the cells from the
  // insertion point on take their left neighbor's entry while the cell at the
  // insertion point takes the new one. A get moves every cell one place left.

  logic   accept;
  logic   full;
  logic   empty;
  cmd_t   cmd;
  entry_t new_entry;
  cnt_t   count_q;
  cnt_t   count_d;

  entry_t cell_entry [CAPACITY];
  logic   cell_later [CAPACITY];

  // The chain needs no wait state, so an offered item is taken in every cycle.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = (count_q == cnt_t'(CAPACITY));
  assign empty  = (count_q == '0);

  assign new_entry.req_time   = start_time_i;
  assign new_entry.request_id = request_id_i;
  assign new_entry.payload    = pl_t'(payload_i);

  always_comb begin
    cmd.key = start_time_i;
    cmd.ins = 1'b0;
    cmd.rem = 1'b0;
    if (accept) begin
      unique case (kind_e'(kind_i))
        KIND_PUT: cmd.ins = !full;
        KIND_GET: cmd.rem = !empty;
        default:  cmd.ins = 1'b0;
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + cnt_t'(1);
    end else if (cmd.rem) begin
      count_d = count_q - cnt_t'(1);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t left;
    logic   left_later;
    entry_t right;
    logic   occ;

    // Occupancy follows from the fill count alone.
    assign occ = (cnt_t'(g) < count_q);

    if (g == 0) begin : g_head
      assign left       = new_entry;
      assign left_later = 1'b0;
    end else begin : g_body
      assign left       = cell_entry[g-1];
      assign left_later = cell_later[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right = cell_entry[g];
    end else begin : g_inner
      assign right = cell_entry[g+1];
    end

    tsrq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .new_i        (new_entry),
      .left_i       (left),
      .left_later_i (left_later),
      .right_i      (right),
      .occ_i        (occ),
      .entry_o      (cell_entry[g]),
      .later_o      (cell_later[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_o  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_o  <= accept;
    end
  end

  // Result fields. A put on a full queue reports the rejected id; a get
  // returns the head; every other case returns zero data. All carry the new count.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_valid_o      <= 1'b0;
      out_start_time_o <= '0;
      out_request_id_o <= '0;
      out_payload_o    <= '0;
      error_code_o     <= ERR_NONE;
      entry_count_o    <= ECNT_W'(count_d);
      if (kind_e'(kind_i) == KIND_PUT && full) begin
        out_request_id_o <= request_id_i;
        error_code_o     <= ERR_FULL;
      end else if (cmd.rem) begin
        out_valid_o      <= 1'b1;
        out_start_time_o <= cell_entry[0].req_time;
        out_request_id_o <= cell_entry[0].request_id;
        out_payload_o    <= PORT_PL_W'(cell_entry[0].payload);
      end
    end
  end

endmodule

/* sv/tsrq_checker.sv */
module tsrq_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_o,
  input logic                     done_o,
  input logic                     out_valid_o,
  input logic [tsrq_pkg::TIME_W-1:0]    out_start_time_o,
  input logic [tsrq_pkg::ID_W-1:0]      out_request_id_o,
  input logic [tsrq_pkg::PORT_PL_W-1:0] out_payload_o,
  input logic                     error_code_o,
  input logic [tsrq_pkg::ECNT_W-1:0]    entry_count_o
);
  import tsrq_pkg::*;

  // Every accepted item yields its result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> done_o)
    else $error("accepted item gave no result");

  // No result appears without an accepted item.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("result without an accepted item");

  // A rejected put never returns a request, and only happens at full count.
  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && error_code_o |->
      !out_valid_o && entry_count_o == ECNT_W'(CAPACITY))
    else $error("full error with a returned request or wrong count");

  // A result that returns nothing carries zero time and payload.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !out_valid_o |-> out_start_time_o == '0 && out_payload_o == '0)
    else $error("nonzero data without a returned request");

  // Two back-to-back results that both return a request shrink the count.
  a_get_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_valid_o && $past(done_o) && $past(out_valid_o) |->
      entry_count_o == $past(entry_count_o) - ECNT_W'(1))
    else $error("count did not drop across consecutive gets");

endmodule

bind time_sorted_request_queue tsrq_checker u_tsrq_checker (.*);

/* tb/sv/time_sorted_request_queue_checker.sv */
`timescale 1ns / 100ps

// Watches the command and result ports of the sorted request queue and keeps
// its own copy of the queue contents to predict every result.
module time_sorted_request_queue_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic                           kind_i,
  input  logic [tsrq_pkg::TIME_W-1:0]    start_time_i,
  input  logic [tsrq_pkg::ID_W-1:0]      request_id_i,
  input  logic [tsrq_pkg::PORT_PL_W-1:0] payload_i,
  input  logic                           done_i,
  input  logic                           out_valid_i,
  input  logic [tsrq_pkg::TIME_W-1:0]    out_start_time_i,
  input  logic [tsrq_pkg::ID_W-1:0]      out_request_id_i,
  input  logic [tsrq_pkg::PORT_PL_W-1:0] out_payload_i,
  input  logic                           error_code_i,
  input  logic [tsrq_pkg::ECNT_W-1:0]    entry_count_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    outstanding_o
);

  import tsrq_pkg::*;

  typedef struct packed {
    logic                 valid;
    time_t                req_time;
    id_t                  request_id;
    logic [PORT_PL_W-1:0] payload;
    err_e                 error;
    logic [ECNT_W-1:0]    count;
  } queue_result_t;

  entry_t        sorted_entries[$];
  queue_result_t expected_results[$];

  initial begin
    fail_count_o  = 0;
    outstanding_o = 0;
  end

  // Applies one command to the local copy of the queue and returns the result
  // it should produce.
  function automatic queue_result_t apply_request(input kind_e kind, input time_t t,
                                                  input id_t id,
                                                  input logic [PORT_PL_W-1:0] pl);
    queue_result_t res;
    entry_t        ent;
    int            pos;
    int            i;
    res = '0;
    if (kind == KIND_PUT) begin
      if (sorted_entries.size() >= CAPACITY) begin
        res.request_id = id;
        res.error      = ERR_FULL;
      end else begin
        // Insert ahead of the first strictly later start time, so ties keep
        // their arrival order.
        pos = sorted_entries.size();
        for (i = 0; i < sorted_entries.size() && pos == sorted_entries.size(); i++) begin
          if (sorted_entries[i].req_time > t) pos = i;
        end
        ent.req_time   = t;
        ent.request_id = id;
        ent.payload    = pl_t'(pl);
        sorted_entries.insert(pos, ent);
      end
    end else if (sorted_entries.size() != 0) begin
      ent            = sorted_entries.pop_front();
      res.valid      = 1'b1;
      res.req_time   = ent.req_time;
      res.request_id = ent.request_id;
      res.payload    = PORT_PL_W'(ent.payload);
    end
    res.count = ECNT_W'(sorted_entries.size());
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    queue_result_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (expected_results.size() == 0) begin
          $error("result strobe with no item pending");
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          compare_field("out_valid", 64'(want.valid), 64'(out_valid_i));
          compare_field("out_start_time", 64'(want.req_time), 64'(out_start_time_i));
          compare_field("out_request_id", 64'(want.request_id), 64'(out_request_id_i));
          compare_field("out_payload", 64'(want.payload), 64'(out_payload_i));
          compare_field("error_code", 64'(want.error), 64'(error_code_i));
          compare_field("entry_count", 64'(want.count), 64'(entry_count_i));
        end
      end
      if (start_i && !busy_i) begin
        expected_results.push_back(apply_request(kind_e'(kind_i), start_time_i,
                                                 request_id_i, payload_i));
      end
      outstanding_o = expected_results.size();
    end
  end

endmodule

/* tb/sv/tb_time_sorted_request_queue.sv */
`timescale 1ns / 100ps

// Top level of the sorted request queue testbench. This module only generates
// commands and decides the verdict; all prediction and result comparison
// happens in the checker instantiated next to the queue.
module tb_time_sorted_request_queue;

  import tsrq_pkg::*;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 start_i      = 1'b0;
  logic                 kind_i       = 1'b0;
  logic [TIME_W-1:0]    start_time_i = '0;
  logic [ID_W-1:0]      request_id_i = '0;
  logic [PORT_PL_W-1:0] payload_i    = '0;

  logic                 busy_o;
  logic                 done_o;
  logic                 out_valid_o;
  logic [TIME_W-1:0]    out_start_time_o;
  logic [ID_W-1:0]      out_request_id_o;
  logic [PORT_PL_W-1:0] out_payload_o;
  logic                 error_code_o;
  logic [ECNT_W-1:0]    entry_count_o;

  int unsigned fail_count;
  int unsigned outstanding;

  // When this is cleared the sender offers a new item on every cycle, which
  // gives a long back-to-back stretch in the middle of the run.
  bit gaps_enabled = 1'b1;

  // The clock runs with a 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  time_sorted_request_queue i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .kind_i           (kind_i),
    .start_time_i     (start_time_i),
    .request_id_i     (request_id_i),
    .payload_i        (payload_i),
    .done_o           (done_o),
    .out_valid_o      (out_valid_o),
    .out_start_time_o (out_start_time_o),
    .out_request_id_o (out_request_id_o),
    .out_payload_o    (out_payload_o),
    .error_code_o     (error_code_o),
    .entry_count_o    (entry_count_o)
  );

  time_sorted_request_queue_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .kind_i           (kind_i),
    .start_time_i     (start_time_i),
    .request_id_i     (request_id_i),
    .payload_i        (payload_i),
    .done_i           (done_o),
    .out_valid_i      (out_valid_o),
    .out_start_time_i (out_start_time_o),
    .out_request_id_i (out_request_id_o),
    .out_payload_i    (out_payload_o),
    .error_code_i     (error_code_o),
    .entry_count_i    (entry_count_o),
    .fail_count_o     (fail_count),
    .outstanding_o    (outstanding)
  );

  // Offers one item and returns at the falling edge after it was taken. The
  // caller is always at a falling edge, so every input changes there and the
  // strobe is assigned at most once per time step. Before the item, the
  // sender may sit idle for a random number of cycles.
  task automatic send_request(input kind_e kind, input time_t t, input id_t id,
                              input logic [PORT_PL_W-1:0] pl);
    while (gaps_enabled && $urandom_range(0, 99) < 27) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i      <= 1'b1;
    kind_i       <= kind;
    start_time_i <= t;
    request_id_i <= id;
    payload_i    <= pl;
    // The item is taken at the first rising edge where the queue is not busy.
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // Start times come from a narrow range in a quarter of the draws so that equal
  // keys are common and arrival order among ties gets exercised; another quarter
  // takes the extremes and the other half takes full-range values.
  function automatic time_t random_req_time();
    case ($urandom_range(0, 3))
      0: return time_t'($urandom_range(0, 7));
      1: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return time_t'(1);
          default: return {{(TIME_W-1){1'b1}}, 1'b0};
        endcase
      end
      default: return time_t'($urandom);
    endcase
  endfunction

  // Issues a random put or get. The put share steers the fill level: a high
  // share drives the queue into the full state, a low one drains it empty.
  // Get items still carry random field values, which the queue must ignore.
  task automatic send_random_request(input int unsigned put_pct);
    kind_e kind;
    kind = ($urandom_range(0, 99) < put_pct) ? KIND_PUT : KIND_GET;
    send_request(kind, random_req_time(), id_t'($urandom), PORT_PL_W'($urandom));
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. A get right after reset must return all zeros.
    send_request(KIND_GET, '0, '0, '0);
    // Largest and smallest field values.
    send_request(KIND_PUT, '1, '1, '1);
    send_request(KIND_PUT, '0, '0, '0);
    // Three entries with the same start time, which must leave in arrival
    // order, then an earlier one that goes in front of them.
    send_request(KIND_PUT, time_t'(7), id_t'(8'h01), 32'hA5A5_A5A5);
    send_request(KIND_PUT, time_t'(7), id_t'(8'h02), 32'h5A5A_5A5A);
    send_request(KIND_PUT, time_t'(7), id_t'(8'h03), 32'h0000_FFFF);
    send_request(KIND_PUT, time_t'(6), id_t'(8'h04), 32'hFFFF_0000);
    // A second entry at the largest time ties with the first one there.
    send_request(KIND_PUT, '1, id_t'(8'h05), 32'h1234_5678);
    send_request(KIND_PUT, time_t'(8), id_t'(8'h06), 32'h8765_4321);
    // Drain all eight entries in sorted order, then get on an empty queue.
    repeat (9) send_request(KIND_GET, time_t'($urandom), id_t'($urandom), $urandom);
    // A put followed directly by a get of the same entry.
    send_request(KIND_PUT, 32'h8000_0000, id_t'(8'hAA), 32'hDEAD_BEEF);
    send_request(KIND_GET, '0, '0, '0);
    send_request(KIND_GET, '1, '1, '1);

    // Random part. A balanced phase moves the fill level around the bottom.
    repeat (60) send_random_request(50);
    // A fill phase pushes the queue past capacity so that full rejections
    // happen repeatedly; its middle runs without any idle cycles.
    for (int n = 0; n < 210; n++) begin
      gaps_enabled = !(n >= 40 && n < 150);
      send_random_request(92);
    end
    gaps_enabled = 1'b1;
    // A drain phase empties the queue again and keeps issuing gets on it.
    repeat (180) send_random_request(8);
    start_i <= 1'b0;

    // Wait until every result has come back, then keep the clock running so
    // that a stray extra result would still be caught.
    for (int n = 0; n < 1000 && outstanding != 0; n++) @(negedge clk_i);
    repeat (4) @(negedge clk_i);

    if (fail_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog. A correct run finishes in well under a tenth of this time.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* filelist.f */
sv/tsrq_pkg.sv
sv/tsrq_cell.sv
sv/time_sorted_request_queue.sv
sv/tsrq_checker.sv
tb/sv/time_sorted_request_queue_checker.sv
tb/sv/tb_time_sorted_request_queue.sv
